// ===== sv/m4i_pkg.sv =====
`timescale 1ns / 1ps
package m4i_pkg;

  typedef struct packed {
    logic signed [31:0] elem_c0;
    logic signed [31:0] elem_c1;
    logic signed [31:0] elem_c2;
    logic signed [31:0] elem_c3;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] res_c0;
    logic signed [31:0] res_c1;
    logic signed [31:0] res_c2;
    logic signed [31:0] res_c3;
    logic [1:0]         res_row;
    logic               singular;
    logic               saturated;
    logic               last_row;
  } out_item_t;

  // multiplier digit width (radix 2^16, msb digit first)
  localparam int MUL_DIGIT = 16;

  // multiplicand select codes
  localparam logic [1:0] ASEL_X = 2'd0;
  localparam logic [1:0] ASEL_P = 2'd1;
  localparam logic [1:0] ASEL_C = 2'd2;

  // 3x3 determinant terms: column of each factor per term, rows are always 0,1,2
  localparam logic [1:0] TRI_COL [0:5][0:2] = '{
    '{2'd0, 2'd1, 2'd2},
    '{2'd1, 2'd2, 2'd0},
    '{2'd2, 2'd0, 2'd1},
    '{2'd2, 2'd1, 2'd0},
    '{2'd0, 2'd2, 2'd1},
    '{2'd1, 2'd0, 2'd2}
  };
  localparam logic TRI_NEG [0:5] = '{1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1};

  typedef struct packed {
    logic       mat_we;
    logic [1:0] mat_waddr;
    logic [1:0] mat_raddr;
    logic [1:0] col;
    logic       lat_x;
    logic       lat_y;
    logic       lat_z;
    logic       mul_load;
    logic [1:0] a_sel;
    logic       b_sel_z;
    logic       mul_step;
    logic       mul_top;
    logic       cof_clr;
    logic       cof_acc;
    logic       cof_minus;
    logic       cof_from_adj;
    logic       adj_we;
    logic [3:0] adj_addr;
    logic       det_clr;
    logic       det_acc;
    logic       q_load;
    logic       q_step;
    logic       q_fin;
  } m4i_cmd_t;

  typedef struct packed {
    logic det_zero;
  } m4i_stat_t;

  // index into the 3x3 minor mapped back to the full matrix
  function automatic logic [1:0] skip_idx(input logic [1:0] n, input logic [1:0] excl);
    skip_idx = (n >= excl) ? n + 2'd1 : n;
  endfunction

endpackage

// ===== sv/m4i_ram.sv =====
`timescale 1ns / 1ps
module m4i_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/m4i_datapath.sv =====
`timescale 1ns / 1ps
module m4i_datapath #(
  parameter int FRAC_BITS  = 16,
  parameter int ELEM_WIDTH = 32
) (
  input  logic                 clk,
  input  m4i_pkg::in_item_t    in_data,
  input  m4i_pkg::m4i_cmd_t    cmd,
  output m4i_pkg::m4i_stat_t   stat,
  output m4i_pkg::out_item_t   out_data
);

  localparam int EW  = ELEM_WIDTH;
  localparam int CW  = 3 * EW + 3;
  localparam int DW  = 4 * EW + 5;
  localparam int DIG = m4i_pkg::MUL_DIGIT;
  localparam int ND  = (EW + DIG - 1) / DIG;
  localparam int BX  = ND * DIG;
  localparam int PRW = CW + BX;
  localparam int SH  = 2 * FRAC_BITS + 1;
  localparam int NW  = CW + SH + 1;
  localparam int DDW = DW + EW + 2;
  localparam int MW  = ((NW > DDW) ? NW : DDW) + 1;
  localparam int QW  = EW + 1;

  // matrix store, one row per word
  logic [4*EW-1:0] mat_wdata;
  logic [4*EW-1:0] mat_rdata;
  logic signed [EW-1:0] elem_sel;

  assign mat_wdata = {EW'($unsigned(in_data.elem_c3)), EW'($unsigned(in_data.elem_c2)),
                      EW'($unsigned(in_data.elem_c1)), EW'($unsigned(in_data.elem_c0))};

  m4i_ram #(.WIDTH(4 * EW), .DEPTH(4)) u_mat (
    .clk   (clk),
    .we    (cmd.mat_we),
    .waddr (cmd.mat_waddr),
    .wdata (mat_wdata),
    .raddr (cmd.mat_raddr),
    .rdata (mat_rdata)
  );

  assign elem_sel = mat_rdata[cmd.col*EW +: EW];

  logic signed [EW-1:0] x_r, y_r, z_r;

  always_ff @(posedge clk) begin
    if (cmd.lat_x) x_r <= elem_sel;
    if (cmd.lat_y) y_r <= elem_sel;
    if (cmd.lat_z) z_r <= elem_sel;
  end

  // digit-serial multiplier
  logic signed [CW-1:0]    ma_r, a_mux;
  logic [BX-1:0]           mb_r, b_mux;
  logic signed [PRW-1:0]   prod_r, prod_nxt;
  logic [DIG-1:0]          dig;
  logic signed [DIG:0]     dig_s;
  logic signed [CW+DIG:0]  pp;
  logic signed [CW-1:0]    cof_r;
  logic signed [DW-1:0]    det_r;

  always_comb begin
    unique case (cmd.a_sel)
      m4i_pkg::ASEL_X: a_mux = CW'(x_r);
      m4i_pkg::ASEL_P: a_mux = CW'(prod_r);
      m4i_pkg::ASEL_C: a_mux = cof_r;
      default:         a_mux = '0;
    endcase
  end

  assign b_mux    = BX'(cmd.b_sel_z ? z_r : y_r);
  assign dig      = mb_r[BX-1 -: DIG];
  assign dig_s    = cmd.mul_top ? {dig[DIG-1], dig} : {1'b0, dig};
  assign pp       = ma_r * dig_s;
  assign prod_nxt = (prod_r <<< DIG) + PRW'(pp);

  always_ff @(posedge clk) begin
    if (cmd.mul_load) begin
      ma_r   <= a_mux;
      mb_r   <= b_mux;
      prod_r <= '0;
    end else if (cmd.mul_step) begin
      prod_r <= prod_nxt;
      mb_r   <= mb_r << DIG;
    end
  end

  // adjugate store
  logic [CW-1:0] adj_rdata;

  m4i_ram #(.WIDTH(CW), .DEPTH(16)) u_adj (
    .clk   (clk),
    .we    (cmd.adj_we),
    .waddr (cmd.adj_addr),
    .wdata (cof_r),
    .raddr (cmd.adj_addr),
    .rdata (adj_rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.cof_clr) begin
      cof_r <= '0;
    end else if (cmd.cof_acc) begin
      cof_r <= cmd.cof_minus ? cof_r - CW'(prod_r) : cof_r + CW'(prod_r);
    end else if (cmd.cof_from_adj) begin
      cof_r <= $signed(adj_rdata);
    end
    if (cmd.det_clr) begin
      det_r <= '0;
    end else if (cmd.det_acc) begin
      det_r <= det_r + DW'(prod_r);
    end
  end

  assign stat.det_zero = (det_r == '0);

  // restoring divider
  logic [CW-1:0] cof_abs;
  logic [DW-1:0] det_abs;
  logic [MW-1:0] rem_r, dd_r;
  logic [QW-1:0] q_r;
  logic          ge;

  assign cof_abs = cof_r[CW-1] ? -cof_r : cof_r;
  assign det_abs = det_r[DW-1] ? -det_r : det_r;
  assign ge      = (rem_r >= dd_r);

  always_ff @(posedge clk) begin
    if (cmd.q_load) begin
      rem_r <= (MW'(cof_abs) << SH) + MW'(det_abs);
      dd_r  <= MW'(det_abs) << (EW + 1);
      q_r   <= '0;
    end else if (cmd.q_step) begin
      rem_r <= ge ? rem_r - dd_r : rem_r;
      dd_r  <= dd_r >> 1;
      q_r   <= {q_r[QW-2:0], ge};
    end
  end

  logic          neg, pos_ovf, neg_ovf, fin_sat;
  logic [EW-1:0] fin_val;

  assign neg     = cof_r[CW-1] ^ det_r[DW-1];
  assign pos_ovf = q_r[EW] | q_r[EW-1];
  assign neg_ovf = q_r[EW] | (q_r[EW-1] & (|q_r[EW-2:0]));

  always_comb begin
    fin_sat = 1'b0;
    if (stat.det_zero) begin
      fin_val = '0;
    end else if (!neg && pos_ovf) begin
      fin_val = {1'b0, {(EW-1){1'b1}}};
      fin_sat = 1'b1;
    end else if (neg && neg_ovf) begin
      fin_val = {1'b1, {(EW-1){1'b0}}};
      fin_sat = 1'b1;
    end else begin
      fin_val = neg ? -q_r[EW-1:0] : q_r[EW-1:0];
    end
  end

  // result row
  logic [31:0] res_r [0:3];
  logic [1:0]  row_r;
  logic        sat_r;

  always_ff @(posedge clk) begin
    if (cmd.q_fin) begin
      res_r[cmd.adj_addr[1:0]] <= 32'(fin_val);
      sat_r <= (cmd.adj_addr[1:0] == 2'd0) ? fin_sat : (sat_r | fin_sat);
      row_r <= cmd.adj_addr[3:2];
    end
  end

  assign out_data.res_c0    = res_r[0];
  assign out_data.res_c1    = res_r[1];
  assign out_data.res_c2    = res_r[2];
  assign out_data.res_c3    = res_r[3];
  assign out_data.res_row   = row_r;
  assign out_data.singular  = stat.det_zero;
  assign out_data.saturated = sat_r;
  assign out_data.last_row  = (row_r == 2'd3);

endmodule

// ===== sv/m4i_ctrl.sv =====
`timescale 1ns / 1ps
module m4i_ctrl #(
  parameter int ELEM_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  input  m4i_pkg::m4i_stat_t stat,
  output m4i_pkg::m4i_cmd_t  cmd
);

  localparam int ND  = (ELEM_WIDTH + m4i_pkg::MUL_DIGIT - 1) / m4i_pkg::MUL_DIGIT;
  localparam int KW  = (ND > 1) ? $clog2(ND) : 1;
  localparam int DCW = $clog2(ELEM_WIDTH + 1);

  localparam logic [4:0] S_LOAD = 5'd0;
  localparam logic [4:0] S_RD0  = 5'd1;
  localparam logic [4:0] S_RD1  = 5'd2;
  localparam logic [4:0] S_RD2  = 5'd3;
  localparam logic [4:0] S_RD3  = 5'd4;
  localparam logic [4:0] S_M1   = 5'd5;
  localparam logic [4:0] S_L2   = 5'd6;
  localparam logic [4:0] S_M2   = 5'd7;
  localparam logic [4:0] S_ACC  = 5'd8;
  localparam logic [4:0] S_COF  = 5'd9;
  localparam logic [4:0] S_DRD0 = 5'd10;
  localparam logic [4:0] S_DRD1 = 5'd11;
  localparam logic [4:0] S_DL   = 5'd12;
  localparam logic [4:0] S_DM   = 5'd13;
  localparam logic [4:0] S_DACC = 5'd14;
  localparam logic [4:0] S_QRD0 = 5'd15;
  localparam logic [4:0] S_QRD1 = 5'd16;
  localparam logic [4:0] S_QLD  = 5'd17;
  localparam logic [4:0] S_QDIV = 5'd18;
  localparam logic [4:0] S_QFIN = 5'd19;
  localparam logic [4:0] S_OUT  = 5'd20;

  logic [4:0]     state_r, state_nxt;
  logic [1:0]     rows_r, rows_nxt;
  logic [3:0]     idx_r, idx_nxt;
  logic [2:0]     t_r, t_nxt;
  logic [KW-1:0]  k_r, k_nxt;
  logic [DCW-1:0] d_r, d_nxt;
  logic [1:0]     r, c;
  logic           k_last;

  assign r         = idx_r[3:2];
  assign c         = idx_r[1:0];
  assign k_last    = (k_r == KW'(ND - 1));
  assign in_stall  = (state_r != S_LOAD);
  assign out_valid = (state_r == S_OUT);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    rows_nxt  = rows_r;
    idx_nxt   = idx_r;
    t_nxt     = t_r;
    k_nxt     = k_r;
    d_nxt     = d_r;
    unique case (state_r) inside
      S_LOAD: begin
        cmd.mat_waddr = rows_r;
        if (in_valid) begin
          cmd.mat_we = 1'b1;
          rows_nxt   = rows_r + 2'd1;
          if (rows_r == 2'd3) begin
            cmd.det_clr = 1'b1;
            idx_nxt     = '0;
            t_nxt       = '0;
            state_nxt   = S_RD0;
          end
        end
      end
      S_RD0: begin
        cmd.mat_raddr = m4i_pkg::skip_idx(2'd0, c);
        cmd.cof_clr   = (t_r == 3'd0);
        state_nxt     = S_RD1;
      end
      S_RD1: begin
        cmd.mat_raddr = m4i_pkg::skip_idx(2'd1, c);
        cmd.col       = m4i_pkg::skip_idx(m4i_pkg::TRI_COL[t_r][0], r);
        cmd.lat_x     = 1'b1;
        state_nxt     = S_RD2;
      end
      S_RD2: begin
        cmd.mat_raddr = m4i_pkg::skip_idx(2'd2, c);
        cmd.col       = m4i_pkg::skip_idx(m4i_pkg::TRI_COL[t_r][1], r);
        cmd.lat_y     = 1'b1;
        state_nxt     = S_RD3;
      end
      S_RD3: begin
        cmd.col      = m4i_pkg::skip_idx(m4i_pkg::TRI_COL[t_r][2], r);
        cmd.lat_z    = 1'b1;
        cmd.mul_load = 1'b1;
        cmd.a_sel    = m4i_pkg::ASEL_X;
        k_nxt        = '0;
        state_nxt    = S_M1;
      end
      S_M1, S_M2, S_DM: begin
        cmd.mul_step = 1'b1;
        cmd.mul_top  = (k_r == '0);
        if (k_last) begin
          k_nxt = '0;
          if (state_r == S_M1) state_nxt = S_L2;
          else if (state_r == S_M2) state_nxt = S_ACC;
          else state_nxt = S_DACC;
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end
      S_L2: begin
        cmd.mul_load = 1'b1;
        cmd.a_sel    = m4i_pkg::ASEL_P;
        cmd.b_sel_z  = 1'b1;
        state_nxt    = S_M2;
      end
      S_ACC: begin
        cmd.cof_acc   = 1'b1;
        cmd.cof_minus = m4i_pkg::TRI_NEG[t_r] ^ r[0] ^ c[0];
        if (t_r == 3'd5) begin
          t_nxt     = '0;
          state_nxt = S_COF;
        end else begin
          t_nxt     = t_r + 3'd1;
          state_nxt = S_RD0;
        end
      end
      S_COF: begin
        cmd.adj_we   = 1'b1;
        cmd.adj_addr = idx_r;
        if (r == 2'd0) begin
          state_nxt = S_DRD0;
        end else if (idx_r == 4'd15) begin
          idx_nxt   = '0;
          state_nxt = S_QRD0;
        end else begin
          idx_nxt   = idx_r + 4'd1;
          state_nxt = S_RD0;
        end
      end
      S_DRD0: begin
        cmd.mat_raddr = c;
        state_nxt     = S_DRD1;
      end
      S_DRD1: begin
        cmd.col   = 2'd0;
        cmd.lat_z = 1'b1;
        state_nxt = S_DL;
      end
      S_DL: begin
        cmd.mul_load = 1'b1;
        cmd.a_sel    = m4i_pkg::ASEL_C;
        cmd.b_sel_z  = 1'b1;
        state_nxt    = S_DM;
      end
      S_DACC: begin
        cmd.det_acc = 1'b1;
        idx_nxt     = idx_r + 4'd1;
        state_nxt   = S_RD0;
      end
      S_QRD0: begin
        cmd.adj_addr = idx_r;
        state_nxt    = S_QRD1;
      end
      S_QRD1: begin
        cmd.cof_from_adj = 1'b1;
        state_nxt        = stat.det_zero ? S_QFIN : S_QLD;
      end
      S_QLD: begin
        cmd.q_load = 1'b1;
        d_nxt      = '0;
        state_nxt  = S_QDIV;
      end
      S_QDIV: begin
        cmd.q_step = 1'b1;
        if (d_r == DCW'(ELEM_WIDTH)) state_nxt = S_QFIN;
        else d_nxt = d_r + 1'b1;
      end
      S_QFIN: begin
        cmd.q_fin    = 1'b1;
        cmd.adj_addr = idx_r;
        if (c == 2'd3) begin
          state_nxt = S_OUT;
        end else begin
          idx_nxt   = idx_r + 4'd1;
          state_nxt = S_QRD0;
        end
      end
      S_OUT: begin
        if (!out_stall) begin
          if (idx_r == 4'd15) begin
            idx_nxt   = '0;
            state_nxt = S_LOAD;
          end else begin
            idx_nxt   = idx_r + 4'd1;
            state_nxt = S_QRD0;
          end
        end
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
      rows_r  <= '0;
      idx_r   <= '0;
      t_r     <= '0;
      k_r     <= '0;
      d_r     <= '0;
    end else begin
      state_r <= state_nxt;
      rows_r  <= rows_nxt;
      idx_r   <= idx_nxt;
      t_r     <= t_nxt;
      k_r     <= k_nxt;
      d_r     <= d_nxt;
    end
  end

endmodule

// ===== sv/matrix4_inverse.sv =====
`timescale 1ns / 1ps
// 4x4 matrix inverse by the adjugate, in signed fixed point (Q16.16 at the default
// parameters). A matrix goes in as four row transfers; after the fourth the block
// forms all sixteen 3x3 cofactors exactly, the determinant along the first column,
// and then gives four result transfers, rows 0 to 3, each element rounded to nearest
// (ties away from zero) and saturated, with saturated set on any row that clipped.
// A zero determinant gives an all-zero matrix with singular set. Rows 0 to 2 are
// only stored; the fourth row starts the work. The work is done by one shared
// digit-serial multiplier (16-bit digits, two steps per product at 32-bit elements)
// used for 192 cofactor products and four determinant products, and by one radix-2
// restoring divider taking ELEM_WIDTH+1 steps per element of the inverse. The input
// is stalled from the fourth row until the last result row has been taken.
module matrix4_inverse #(
  parameter int FRAC_BITS  = 16,
  parameter int ELEM_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  m4i_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output m4i_pkg::out_item_t out_data
);

  // command and status between sequencer and arithmetic
  m4i_pkg::m4i_cmd_t  cmd;
  m4i_pkg::m4i_stat_t stat;

  // sequencer: row loading, cofactor terms, determinant, division, result handshake
  m4i_ctrl #(.ELEM_WIDTH(ELEM_WIDTH)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // arithmetic: matrix and adjugate stores, multiplier, accumulators, divider
  m4i_datapath #(.FRAC_BITS(FRAC_BITS), .ELEM_WIDTH(ELEM_WIDTH)) u_dp (
    .clk      (clk),
    .in_data  (in_data),
    .cmd      (cmd),
    .stat     (stat),
    .out_data (out_data)
  );

  // no input is taken while a result row is on offer
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !in_stall |-> !out_valid)
    else $error("input open while result pending");

  // once the last row is taken the block is ready for the next matrix
  a_back_to_load: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_data.last_row |=> !in_stall)
    else $error("not ready after last row");

  // a singular matrix gives zeros and never flags clipping
  a_singular_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.singular |-> !out_data.saturated && out_data.res_c0 == 0 &&
      out_data.res_c1 == 0 && out_data.res_c2 == 0 && out_data.res_c3 == 0)
    else $error("singular row not zero");

endmodule
